/* rtl/smac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_pkg
// Shared types and constants of the stepper axis move controller.
// ----------------------------------------------------------------------------
package smac_pkg;

  // fixed field and datapath widths
  localparam int COUNT_W      = 32;
  localparam int TARGET_W     = 24;
  localparam int REPORT_POS_W = 24;
  localparam int CFG_DATA_W   = 16;
  localparam int FRAC_BITS    = 8;
  localparam int DIVISOR_W    = 16;
  localparam int DIVIDEND_W   = COUNT_W + FRAC_BITS;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] PPU_RESET  = 16'd256;
  localparam logic [CFG_DATA_W-1:0] RAMP_RESET = 16'd16;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_PPU  = 1'b0,
    CFG_RAMP = 1'b1
  } cfg_idx_t;

  // request kinds
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_MOVE = 1'b1
  } kind_t;

  // axis mode
  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_ARMED   = 2'd1,
    MODE_PLUS    = 2'd2,
    MODE_MINUS   = 2'd3
  } mode_t;

  // report codes
  typedef enum logic [2:0] {
    CODE_STARTED     = 3'd0,
    CODE_STOPPED     = 3'd1,
    CODE_POSITION    = 3'd2,
    CODE_LIMIT_PLUS  = 3'd3,
    CODE_LIMIT_MINUS = 3'd4
  } code_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_EVAL = 2'd2
  } state_t;

  // request payload
  typedef struct packed {
    logic                kind;
    logic [COUNT_W-1:0]  pulse_count;
    logic                limit_plus;
    logic                limit_minus;
    logic [TARGET_W-1:0] target_position;
  } req_t;

  // response payload
  typedef struct packed {
    logic                    motor_run;
    logic                    motor_direction;
    logic                    fast_speed;
    logic                    report_valid;
    logic [2:0]              report_code;
    logic [REPORT_POS_W-1:0] report_position;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
  } ctrl_sts_t;

endpackage

/* rtl/stepper_axis_move_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_axis_move_controller
// One stepper axis, point to point, slow ramps at both ends and fast middle.
// ----------------------------------------------------------------------------
// A tick request runs the divider steps, one handoff to evaluation and one commit;
// the commit waits while the output register still holds an unread response. A
// move request goes straight to evaluation and commit. One request is in work at a
// time; the next is accepted while a finished response still waits. The
// bit-serial divider computes count * 256 / scale for tick requests. Reset is
// synchronous and restores the configuration defaults and a stopped axis.
module stepper_axis_move_controller import smac_pkg::*; #(
  parameter int POSITION_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // configuration writes are taken whenever out of reset
  assign cfg_ready = !rst;

  smac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  smac_dp #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

/* rtl/smac_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_div
// Restoring divider, one quotient bit per cycle, for the position scaling.
// ----------------------------------------------------------------------------
module smac_div import smac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // one trial subtraction per step
  assign rem_sh = {rem, quo[DIVIDEND_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};
  assign diff   = rem_sh - {1'b0, divisor};

  // step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

/* rtl/smac_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_ctrl
// Sequencer: accepts a request, runs the divider, commits the result.
// ----------------------------------------------------------------------------
module smac_ctrl import smac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_kind,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;
  logic   rsp_valid_next;

  // state register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        // nothing is taken while reset is high
        req_ready = !rst;
        if (req_valid && req_ready) begin
          cmd.load = 1'b1;
          if (req_kind == KIND_MOVE) begin
            state_next = S_EVAL;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_EVAL;
      end
      S_EVAL: begin
        // wait for the output register to be free
        if (!rsp_valid || rsp_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register occupancy
  always_comb begin
    if (cmd.commit) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
    else rsp_valid_next = rsp_valid;
  end

endmodule

/* rtl/smac_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_dp
// Datapath: configuration, axis state, position scaling and move decisions.
// ----------------------------------------------------------------------------
module smac_dp import smac_pkg::*; #(
  parameter int POSITION_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  req,
  input  logic                  cfg_valid,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  output rsp_t                  rsp
);

  localparam int PB    = POSITION_BITS;
  localparam int SW    = ((PB > DIVISOR_W) ? PB : DIVISOR_W) + 2;
  localparam int PROD_W = PB + DIVISOR_W;
  localparam int THR_W = PROD_W - FRAC_BITS;

  // configuration
  logic [CFG_DATA_W-1:0] ppu;
  logic [CFG_DATA_W-1:0] ramp;
  logic [DIVISOR_W-1:0]  scale;

  // latched request
  logic                kind_q;
  logic [COUNT_W-1:0]  count_q;
  logic                lim_p_q;
  logic                lim_m_q;
  logic [TARGET_W-1:0] tp_q;

  // axis state
  mode_t          mode, mode_next;
  logic [PB-1:0]  target, target_next;
  logic [PB-1:0]  start_pos, start_pos_next;
  logic [PB-1:0]  prev_pos, prev_pos_next;
  logic           run_flag, run_flag_next;
  logic           dir_flag, dir_flag_next;
  logic           fast_flag, fast_flag_next;

  // scaling
  logic [PROD_W-1:0]     prod;
  logic [THR_W-1:0]      thr;
  logic [DIVIDEND_W-1:0] quotient;
  logic [PB-1:0]         cur;
  logic [DIVIDEND_W-1:0] count_w;
  logic [DIVIDEND_W-1:0] thr_w;
  logic                  lt;
  logic                  gt;
  logic [31:0]           tp32;

  // speed choice
  logic [PB-1:0]        lo;
  logic [PB-1:0]        hi;
  logic signed [SW-1:0] c_s, lo_s, hi_s, r_s;
  logic                 fast_calc;

  // report
  logic          rep;
  code_t         code;
  logic [PB-1:0] rpos;
  logic [31:0]   rpos32;
  rsp_t          rsp_next;
  logic          plus;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ppu  <= PPU_RESET;
      ramp <= RAMP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PPU:  ppu  <= cfg_data;
        CFG_RAMP: ramp <= cfg_data;
        default: ;
      endcase
    end
  end

  // a zero scale counts as one
  assign scale = (ppu == '0) ? DIVISOR_W'(1) : ppu;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= req.kind;
      count_q <= req.pulse_count;
      lim_p_q <= req.limit_plus;
      lim_m_q <= req.limit_minus;
      tp_q    <= req.target_position;
    end
  end

  // target threshold in pulses, refreshed every cycle
  assign prod = PROD_W'(target) * PROD_W'(scale);
  always_ff @(posedge clk) begin
    thr <= prod[PROD_W-1:FRAC_BITS];
  end

  // position = count * 256 / scale
  smac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({req.pulse_count, {FRAC_BITS{1'b0}}}),
    .divisor  (scale),
    .done     (sts.div_done),
    .quotient (quotient)
  );

  // saturate position to the position width
  assign cur = (|quotient[DIVIDEND_W-1:PB]) ? {PB{1'b1}} : quotient[PB-1:0];

  // count against threshold
  assign count_w = DIVIDEND_W'(count_q);
  assign thr_w   = DIVIDEND_W'(thr);
  assign lt      = count_w < thr_w;
  assign gt      = count_w > thr_w;

  // travel bounds, symmetric for both directions
  assign plus = (mode == MODE_PLUS);
  assign lo   = plus ? start_pos : target;
  assign hi   = plus ? target : start_pos;
  assign c_s  = SW'(cur);
  assign lo_s = SW'(lo);
  assign hi_s = SW'(hi);
  assign r_s  = SW'(ramp);
  assign fast_calc = !((hi_s - lo_s) < r_s) && (c_s > lo_s + r_s) && (c_s < hi_s - r_s);

  // new target from a move request
  assign tp32 = 32'(tp_q);

  // move decisions
  always_comb begin
    mode_next      = mode;
    target_next    = target;
    start_pos_next = start_pos;
    prev_pos_next  = prev_pos;
    run_flag_next  = run_flag;
    dir_flag_next  = dir_flag;
    fast_flag_next = fast_flag;
    rep            = 1'b0;
    code           = CODE_STARTED;
    rpos           = cur;
    if (kind_q == KIND_MOVE) begin
      target_next = tp32[PB-1:0];
      mode_next   = MODE_ARMED;
    end else begin
      case (mode)
        MODE_ARMED: begin
          rep = 1'b1;
          if (lt || gt) begin
            mode_next      = lt ? MODE_PLUS : MODE_MINUS;
            dir_flag_next  = lt;
            code           = CODE_STARTED;
            start_pos_next = cur;
            run_flag_next  = 1'b1;
            fast_flag_next = 1'b0;
          end else begin
            mode_next = MODE_STOPPED;
            code      = CODE_STOPPED;
          end
        end
        MODE_PLUS, MODE_MINUS: begin
          if (plus ? !lt : !gt) begin
            // target reached
            run_flag_next = 1'b0;
            mode_next     = MODE_STOPPED;
            rep           = 1'b1;
            code          = CODE_STOPPED;
          end else begin
            fast_flag_next = fast_calc;
            if (prev_pos != cur) begin
              rep  = 1'b1;
              code = CODE_POSITION;
            end
            prev_pos_next = cur;
            // limit switch of the running direction
            if (plus ? lim_p_q : lim_m_q) begin
              run_flag_next = 1'b0;
              mode_next     = MODE_STOPPED;
              rep           = 1'b1;
              code          = plus ? CODE_LIMIT_PLUS : CODE_LIMIT_MINUS;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // response payload
  assign rpos32 = 32'(rpos);
  always_comb begin
    rsp_next.motor_run       = run_flag_next;
    rsp_next.motor_direction = dir_flag_next;
    rsp_next.fast_speed      = fast_flag_next;
    rsp_next.report_valid    = rep;
    rsp_next.report_code     = rep ? code : 3'd0;
    rsp_next.report_position = rep ? rpos32[REPORT_POS_W-1:0] : '0;
  end

  // axis state update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_STOPPED;
      target    <= '0;
      start_pos <= '0;
      prev_pos  <= '0;
      run_flag  <= 1'b0;
      dir_flag  <= 1'b0;
      fast_flag <= 1'b0;
    end else if (cmd.commit) begin
      mode      <= mode_next;
      target    <= target_next;
      start_pos <= start_pos_next;
      prev_pos  <= prev_pos_next;
      run_flag  <= run_flag_next;
      dir_flag  <= dir_flag_next;
      fast_flag <= fast_flag_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) rsp <= rsp_next;
  end

endmodule

/* rtl/smac_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_checker
// Port-level checks of the stepper axis move controller.
// ----------------------------------------------------------------------------
module smac_checker import smac_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // reset empties the response register
  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in work");

  // a start report comes with the motor running
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.report_valid && rsp.report_code == CODE_STARTED |-> rsp.motor_run)
    else $error("start report without motor run");

  // limit reports come with the motor halted
  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.report_valid &&
    (rsp.report_code == CODE_LIMIT_PLUS || rsp.report_code == CODE_LIMIT_MINUS)
    |-> !rsp.motor_run)
    else $error("limit report with motor running");

endmodule

bind stepper_axis_move_controller smac_checker u_smac_checker (.*);
